// File: rtl/adcss_pkg.sv
// ============================================================================
// adcss_pkg
// Shared types, constants and helper functions for the ADC scan sequencer.
// ============================================================================
package adcss_pkg;

   localparam int CHANNELS     = 8;
   localparam int BUFFER_DEPTH = 256;

   localparam int MASK_W  = 8;
   localparam int CH_W    = 3;
   localparam int CNT_W   = 4;
   localparam int FRAME_W = 9;
   localparam int RING_W  = $clog2(BUFFER_DEPTH);
   localparam int LEN_W   = RING_W + 1;
   localparam int PROD_W  = FRAME_W + CNT_W;
   localparam int DATA_W  = 8;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 2;

   localparam logic [MASK_W-1:0]  CHAN_MASK    = MASK_W'((1 << CHANNELS) - 1);
   localparam logic [MASK_W-1:0]  ENABLE_RESET = 8'hFF;
   localparam logic               MODE_RESET   = 1'b1;
   localparam logic [FRAME_W-1:0] FRAME_RESET  = 9'd1;
   localparam logic [DATA_W-1:0]  REQ_MAX      = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_STOP   = 2'd2
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_CHANNEL_ENABLE = 2'd0,
      REG_SCAN_MODE      = 2'd1,
      REG_FRAME_COUNT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [MASK_W-1:0]  channel_enable;
      logic               scan_mode;
      logic [FRAME_W-1:0] frame_count;
   } cfg_type;

   // Raised in the cycle that the channel mask is written, so the scan
   // position follows the new mask at the same edge.
   typedef struct packed {
      logic            set_pos;
      logic [CH_W-1:0] first_pos;
   } csr_evt_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] sample;
      logic              tx_paused;
   } req_type;

   typedef struct packed {
      logic              write_valid;
      logic [RING_W-1:0] write_index;
      logic [DATA_W-1:0] sample_out;
      logic [CH_W-1:0]   next_channel;
      logic              start_conversion;
      logic              send_frame;
      logic [DATA_W-1:0] pending_requests;
      logic              running;
   } rsp_type;

   function automatic logic [CH_W-1:0] first_enabled(input logic [MASK_W-1:0] mask);
      logic [CH_W-1:0] pos;
      logic            found;
      pos   = '0;
      found = 1'b0;
      for (int i = 0; i < MASK_W; i++) begin
         if (mask[i] && !found) begin
            pos   = CH_W'(i);
            found = 1'b1;
         end
      end
      return pos;
   endfunction

   // Lowest enabled channel above pos; the top bit is set when one exists.
   function automatic logic [CH_W:0] next_enabled(input logic [MASK_W-1:0] mask,
                                                  input logic [CH_W-1:0]   pos);
      logic [CH_W:0] res;
      res = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (mask[i] && (i > int'(pos))) begin
            res = {1'b1, CH_W'(i)};
         end
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] enabled_count(input logic [MASK_W-1:0] mask);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < MASK_W; i++) begin
         n = n + CNT_W'(mask[i]);
      end
      return n;
   endfunction

endpackage

// File: rtl/adcss_req_if.sv
// ============================================================================
// adcss_req_if
// Command and sample channel into the scan sequencer.
// ============================================================================
interface adcss_req_if import adcss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DATA_W-1:0] sample;
   logic              tx_paused;

   modport source (output valid, command, sample, tx_paused, input ready);
   modport sink   (input valid, command, sample, tx_paused, output ready);
endinterface

// File: rtl/adcss_rsp_if.sv
// ============================================================================
// adcss_rsp_if
// Result channel out of the scan sequencer.
// ============================================================================
interface adcss_rsp_if import adcss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [RING_W-1:0] write_index;
   logic [DATA_W-1:0] sample_out;
   logic [CH_W-1:0]   next_channel;
   logic              start_conversion;
   logic              send_frame;
   logic [DATA_W-1:0] pending_requests;
   logic              running;

   modport source (output valid, write_valid, write_index, sample_out, next_channel,
                   start_conversion, send_frame, pending_requests, running,
                   input ready);
   modport sink   (input valid, write_valid, write_index, sample_out, next_channel,
                   start_conversion, send_frame, pending_requests, running,
                   output ready);
endinterface

// File: rtl/adcss_csr_if.sv
// ============================================================================
// adcss_csr_if
// Register write channel of the scan sequencer.
// ============================================================================
interface adcss_csr_if import adcss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   index;
   logic [FRAME_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/adcss_csr.sv
// ============================================================================
// adcss_csr
// Configuration registers: channel mask, scan mode and frame count.
// ============================================================================
module adcss_csr import adcss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   adcss_csr_if.sink   csr_bus,
   output cfg_type     cfg,
   output csr_evt_type evt
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid;

   always_comb begin
      cfg_in        = cfg_ff;
      evt.set_pos   = 1'b0;
      evt.first_pos = first_enabled(csr_bus.data[MASK_W-1:0] & CHAN_MASK);
      if (wr) begin
         case (csr_bus.index)
            REG_CHANNEL_ENABLE: begin
               cfg_in.channel_enable = csr_bus.data[MASK_W-1:0];
               evt.set_pos           = 1'b1;
            end
            REG_SCAN_MODE: begin
               cfg_in.scan_mode = csr_bus.data[0];
            end
            REG_FRAME_COUNT: begin
               cfg_in.frame_count = csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_enable <= ENABLE_RESET;
         cfg_ff.scan_mode      <= MODE_RESET;
         cfg_ff.frame_count    <= FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/adcss_step.sv
// ============================================================================
// adcss_step
// Input register, scan state and the single-pass update for one item.
// ============================================================================
module adcss_step import adcss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   adcss_req_if.sink   req_bus,
   input  cfg_type     cfg,
   input  csr_evt_type evt,
   input  logic        out_room,
   output logic        push,
   output rsp_type     push_data
);

   logic              in_valid_ff, in_valid_in;
   req_type           in_ff;
   logic              active_ff, active_in;
   logic [CH_W-1:0]   pos_ff, pos_in;
   logic [RING_W-1:0] ring_ff, ring_in;
   logic [DATA_W-1:0] reqcnt_ff, reqcnt_in;

   logic              accept, advance;
   logic [MASK_W-1:0] mask;
   logic [CNT_W-1:0]  count;
   logic [FRAME_W-1:0] fc_eff;
   logic [PROD_W-1:0] prod;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  ring_plus;
   logic [RING_W-1:0] ring_adv;
   logic [CH_W:0]     nxt;
   rsp_type           res;

   assign advance       = in_valid_ff && out_room;
   assign req_bus.ready = !in_valid_ff || out_room;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_valid_in   = accept || (in_valid_ff && !advance);

   // Ring length from the current registers.
   assign mask      = cfg.channel_enable & CHAN_MASK;
   assign count     = enabled_count(mask);
   assign fc_eff    = (cfg.frame_count == '0) ? FRAME_W'(1) : cfg.frame_count;
   assign prod      = PROD_W'(fc_eff) * PROD_W'(count);
   assign len       = cfg.scan_mode ? LEN_W'(count) :
                      (prod > PROD_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : LEN_W'(prod);
   assign ring_plus = {1'b0, ring_ff} + LEN_W'(1);
   assign ring_adv  = (ring_plus >= len) ? '0 : ring_plus[RING_W-1:0];
   assign nxt       = next_enabled(mask, pos_ff);

   always_comb begin
      active_in            = active_ff;
      pos_in               = pos_ff;
      ring_in              = ring_ff;
      reqcnt_in            = reqcnt_ff;
      res.write_valid      = 1'b0;
      res.write_index      = ring_ff;
      res.sample_out       = '0;
      res.start_conversion = 1'b0;
      res.send_frame       = 1'b0;
      case (in_ff.command)
         CMD_START: begin
            reqcnt_in       = '0;
            ring_in         = '0;
            res.write_index = '0;
            active_in       = (count != '0);
         end
         CMD_STOP: begin
            active_in = 1'b0;
            reqcnt_in = '0;
         end
         CMD_SAMPLE: begin
            if (active_ff && (count != '0)) begin
               res.write_valid = 1'b1;
               res.sample_out  = in_ff.sample;
               ring_in         = ring_adv;
               if (nxt[CH_W]) begin
                  pos_in               = nxt[CH_W-1:0];
                  res.start_conversion = 1'b1;
               end else begin
                  // End of scan: wrap to the first channel and decide on a send.
                  pos_in = first_enabled(mask);
                  if (cfg.scan_mode) begin
                     if (in_ff.tx_paused) begin
                        if (reqcnt_ff != REQ_MAX) begin
                           reqcnt_in = reqcnt_ff + DATA_W'(1);
                        end
                     end else begin
                        res.send_frame = 1'b1;
                     end
                  end else if (!in_ff.tx_paused && (ring_adv == '0)) begin
                     res.send_frame = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.next_channel     = pos_in;
      res.pending_requests = reqcnt_in;
      res.running          = active_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.command   <= req_bus.command;
         in_ff.sample    <= req_bus.sample;
         in_ff.tx_paused <= req_bus.tx_paused;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         active_ff   <= 1'b0;
         pos_ff      <= first_enabled(ENABLE_RESET & CHAN_MASK);
         ring_ff     <= '0;
         reqcnt_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            active_ff <= active_in;
            pos_ff    <= pos_in;
            ring_ff   <= ring_in;
            reqcnt_ff <= reqcnt_in;
         end
         if (evt.set_pos) begin
            pos_ff <= evt.first_pos;
         end
      end
   end

   assign push      = advance;
   assign push_data = res;

endmodule

// File: rtl/adcss_outbuf.sv
// ============================================================================
// adcss_outbuf
// Result register with a skid entry, so a single stalled result does not stop input.
// ============================================================================
module adcss_outbuf import adcss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic       room,
   adcss_rsp_if.source rsp_bus
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign room = !skid_valid_ff;
   assign pop  = out_valid_ff && rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.write_valid      = out_ff.write_valid;
   assign rsp_bus.write_index      = out_ff.write_index;
   assign rsp_bus.sample_out       = out_ff.sample_out;
   assign rsp_bus.next_channel     = out_ff.next_channel;
   assign rsp_bus.start_conversion = out_ff.start_conversion;
   assign rsp_bus.send_frame       = out_ff.send_frame;
   assign rsp_bus.pending_requests = out_ff.pending_requests;
   assign rsp_bus.running          = out_ff.running;

endmodule

// File: rtl/adc_scan_sequencer.sv
// ============================================================================
// adc_scan_sequencer
// Scan controller for an eight-channel ADC: ring write index, channel select,
// retrigger and frame send requests.
// ============================================================================
//
//   Channel   Dir   Handshake      Payload
//   req_bus   in    valid/ready    command, sample, tx_paused
//   rsp_bus   out   valid/ready    write_valid .. running (one per command)
//   csr_bus   in    valid/ready    index, data (ready is always high)
//
// One command is taken per clock while input is not stalled, and each gives
// exactly one result through the input register and then the result register.
// The update of the scan state is a single pass of short logic between them.
// The result side holds up to two results (result register plus skid entry);
// input stalls only once both are full and the input register is occupied.
// Reset is synchronous and restores the registers to their documented values
// and the scan state to stopped, index zero, first channel.
//
// Users must write registers only with no command in flight (not enforced).
// A mask write moves scan position to the first enabled channel at once.
module adc_scan_sequencer import adcss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   adcss_req_if.sink   req_bus,
   adcss_rsp_if.source rsp_bus,
   adcss_csr_if.sink   csr_bus
);

   cfg_type     cfg;
   csr_evt_type evt;
   logic        out_room;
   logic        push;
   rsp_type     push_data;

   adcss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .evt     (evt)
   );

   adcss_step u_step (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .evt       (evt),
      .out_room  (out_room),
      .push      (push),
      .push_data (push_data)
   );

   adcss_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (out_room),
      .rsp_bus   (rsp_bus)
   );

   // Input may only back up while a result is actually waiting downstream.
   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("input stalled with no result pending");

   // A stored sample means the scan is still running afterwards.
   a_write_running : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.write_valid) |-> rsp_bus.running)
      else $error("sample stored while stopped");

   // Retrigger happens only mid-scan, send only at scan end.
   a_send_not_retrigger : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.send_frame) |-> (!rsp_bus.start_conversion &&
                                                 rsp_bus.write_valid))
      else $error("frame send outside end of scan");

   // Reset empties the result side.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

// File: test/tb_adc_scan_sequencer.sv
// ----------------------------------------------------------------------------
// tb_adc_scan_sequencer
// Self-checking testbench for the ADC scan sequencer. A queue of commands
// feeds a bursty driver, a clocked predictor computes the result of every
// accepted beat, and a monitor with its own stall pattern compares each
// result beat field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_adc_scan_sequencer import adcss_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam realtime CLK_PERIOD    = 8ns;
   localparam int      RESET_CYCLES  = 7;
   localparam int      RANDOM_ITEMS  = 1350;
   localparam int      CYCLE_LIMIT   = 400000;
   localparam int      TAIL_CYCLES   = 8;

   // Encodings outside the documented ranges; the block must ignore them.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam logic [IDX_W-1:0] REG_RESERVED = 2'd3;

   logic clock;
   logic reset;

   adcss_req_if req_bus ();
   adcss_rsp_if rsp_bus ();
   adcss_csr_if csr_bus ();

   adc_scan_sequencer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Commands waiting to be driven and results waiting to be seen.
   req_type queued_commands[$];
   rsp_type predicted_results[$];

   // Predictor copy of the registers and the scan state.
   logic [MASK_W-1:0]  cfg_mask;
   logic               cfg_scan_mode;
   logic [FRAME_W-1:0] cfg_frames;
   logic               run_active;
   logic [CH_W-1:0]    scan_pos;
   logic [RING_W-1:0]  ring_pos;
   logic [DATA_W-1:0]  req_count;

   // Bookkeeping.
   int  items_queued   = 0;
   int  results_seen   = 0;
   int  failures       = 0;
   int  reg_writes     = 0;
   int  sends_seen     = 0;
   int  samples_stored = 0;
   int  peak_pending   = 0;
   int  cycle_count    = 0;
   int  phase_count    = 0;

   // Sender burst shaping and receiver stall pattern.
   bit      sender_steady = 1'b0;
   int      burst_left    = 0;
   int      gap_left      = 0;
   int      sink_tick     = 0;
   int      sink_mode     = 0;
   req_type next_beat;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor helpers
   // -------------------------------------------------------------------------

   function automatic logic [CH_W-1:0] lowest_channel(input logic [MASK_W-1:0] mask);
      for (int ch = 0; ch < MASK_W; ch++) begin
         if (mask[ch]) return CH_W'(ch);
      end
      return '0;
   endfunction

   function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                          input logic [FRAME_W-1:0] value);
      case (idx)
         REG_CHANNEL_ENABLE: begin
            cfg_mask = value[MASK_W-1:0];
            scan_pos = lowest_channel(value[MASK_W-1:0]);
         end
         REG_SCAN_MODE:   cfg_scan_mode = value[0];
         REG_FRAME_COUNT: cfg_frames = value;
         default: ;
      endcase
   endfunction

   // Advances the scan state by one accepted command and returns the result
   // beat that the block must produce for it.
   function automatic rsp_type predict_scan_step(input req_type cmd);
      rsp_type res;
      int      n_on;
      int      frames;
      int      ring_len;
      int      nxt;
      n_on            = $countones(cfg_mask);
      res             = '0;
      res.write_index = ring_pos;
      case (cmd.command)
         CMD_START: begin
            req_count       = '0;
            ring_pos        = '0;
            res.write_index = '0;
            run_active      = (n_on != 0);
         end
         CMD_STOP: begin
            run_active = 1'b0;
            req_count  = '0;
         end
         CMD_SAMPLE: begin
            if (run_active && n_on != 0) begin
               frames   = (cfg_frames == '0) ? 1 : int'(cfg_frames);
               ring_len = cfg_scan_mode ? n_on : frames * n_on;
               if (ring_len > BUFFER_DEPTH) ring_len = BUFFER_DEPTH;
               res.write_valid = 1'b1;
               res.sample_out  = cmd.sample;
               // An index left beyond a shortened ring wraps on this advance.
               if (int'(ring_pos) + 1 >= ring_len) ring_pos = '0;
               else ring_pos = ring_pos + RING_W'(1);

               nxt = MASK_W;
               for (int ch = MASK_W - 1; ch >= 0; ch--) begin
                  if (cfg_mask[ch] && ch > int'(scan_pos)) nxt = ch;
               end

               if (nxt < MASK_W) begin
                  scan_pos             = CH_W'(nxt);
                  res.start_conversion = 1'b1;
               end else begin
                  // End of scan: back to the first channel, then decide on a send.
                  scan_pos = lowest_channel(cfg_mask);
                  if (cfg_scan_mode) begin
                     if (cmd.tx_paused) begin
                        if (req_count != REQ_MAX) req_count = req_count + DATA_W'(1);
                     end else begin
                        res.send_frame = 1'b1;
                     end
                  end else if (!cmd.tx_paused && ring_pos == '0) begin
                     res.send_frame = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      res.next_channel     = scan_pos;
      res.pending_requests = req_count;
      res.running          = run_active;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Driver: presents queued commands in bursts and predicts every accepted
   // beat. Register writes are folded into the predictor at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    = 0;
         gap_left      = 0;
         cfg_mask      = ENABLE_RESET;
         cfg_scan_mode = MODE_RESET;
         cfg_frames    = FRAME_RESET;
         run_active    = 1'b0;
         ring_pos      = '0;
         req_count     = '0;
         scan_pos      = lowest_channel(ENABLE_RESET);
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            apply_register(csr_bus.index, csr_bus.data);
            reg_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted_results.push_back(predict_scan_step(
               req_type'({req_bus.command, req_bus.sample, req_bus.tx_paused})));
         end
         // A new beat goes out only when the bus is free or the current beat
         // was just taken.
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (queued_commands.size() != 0) begin
               next_beat = queued_commands.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.command   <= next_beat.command;
               req_bus.sample    <= next_beat.sample;
               req_bus.tx_paused <= next_beat.tx_paused;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  if (sender_steady) gap_left = 0;
                  else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(8, 20);
                  else gap_left = $urandom_range(1, 4);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: takes result beats under a changing stall pattern and checks
   // them against the oldest prediction.
   // -------------------------------------------------------------------------
   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, label, want,
                  got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            got = {rsp_bus.write_valid, rsp_bus.write_index, rsp_bus.sample_out,
                   rsp_bus.next_channel, rsp_bus.start_conversion, rsp_bus.send_frame,
                   rsp_bus.pending_requests, rsp_bus.running};
            if (predicted_results.size() == 0) begin
               failures++;
               $display("%0t: result beat with nothing expected, expected none, actual %h",
                        $realtime, got);
            end else begin
               want = predicted_results.pop_front();
               check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
               check_field("write_index", 32'(want.write_index), 32'(got.write_index));
               check_field("sample_out", 32'(want.sample_out), 32'(got.sample_out));
               check_field("next_channel", 32'(want.next_channel),
                           32'(got.next_channel));
               check_field("start_conversion", 32'(want.start_conversion),
                           32'(got.start_conversion));
               check_field("send_frame", 32'(want.send_frame), 32'(got.send_frame));
               check_field("pending_requests", 32'(want.pending_requests),
                           32'(got.pending_requests));
               check_field("running", 32'(want.running), 32'(got.running));
               if (want.send_frame) sends_seen++;
               if (want.write_valid) samples_stored++;
               if (int'(want.pending_requests) > peak_pending)
                  peak_pending = int'(want.pending_requests);
            end
         end
         // The monitor draws its stall pattern at random from: always ready, random,
         // a short periodic pattern, or long on/off stretches.
         sink_tick++;
         if (sink_tick % 256 == 0) sink_mode = $urandom_range(0, 3);
         case (sink_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_bus.ready <= (sink_tick % 5 < 3);
            default: rsp_bus.ready <= sink_tick[4];
         endcase
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                             input logic paused);
      queued_commands.push_back(req_type'({cmd, value, paused}));
      items_queued++;
   endtask

   task automatic queue_samples(input int count, input int paused_pct);
      repeat (count) begin
         queue_item(CMD_SAMPLE, DATA_W'($urandom_range(0, 255)),
                    ($urandom_range(0, 99) < paused_pct));
      end
   endtask

   // Holds the caller until every queued command has produced its result.
   task automatic wait_results();
      @(posedge clock);
      while (results_seen < items_queued) @(posedge clock);
   endtask

   // Raises the register write channel and holds it until the beat is taken.
   // The caller lowers valid after its last write.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FRAME_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int                 directed_items;
      int                 n_on;
      int                 paused_pct;
      int                 pick;
      logic [MASK_W-1:0]  cur_mask;
      logic [FRAME_W-1:0] frames;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_SAMPLE;
      req_bus.sample    = '0;
      req_bus.tx_paused = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_CHANNEL_ENABLE;
      csr_bus.data      = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all channels, scan mode. A sample before start and
      // the reserved command are both ignored; a full scan ends in a send;
      // stop clears the run and a later sample is ignored again.
      queue_item(CMD_SAMPLE, 8'hFF, 1'b1);
      queue_item(CMD_RESERVED, 8'hAA, 1'b1);
      queue_item(CMD_START, 8'h00, 1'b0);
      for (int ch = 0; ch < 8; ch++) begin
         queue_item(CMD_SAMPLE, (ch == 0) ? 8'h00 : (ch == 7) ? 8'hFF : DATA_W'(ch * 37),
                    1'b0);
      end
      queue_item(CMD_STOP, 8'h55, 1'b0);
      queue_item(CMD_SAMPLE, 8'h55, 1'b0);
      wait_results();

      // Two channels, scan mode; a paused end of scan counts a request.
      write_reg(REG_CHANNEL_ENABLE, 9'h181);
      csr_bus.valid <= 1'b0;
      queue_item(CMD_START, 8'h00, 1'b1);
      queue_item(CMD_SAMPLE, 8'h80, 1'b0);
      queue_item(CMD_SAMPLE, 8'h7F, 1'b1);
      wait_results();

      // Frame mode with a zero frame count, which behaves as one frame.
      write_reg(REG_SCAN_MODE, 9'h000);
      write_reg(REG_FRAME_COUNT, 9'h000);
      csr_bus.valid <= 1'b0;
      queue_item(CMD_SAMPLE, 8'h01, 1'b0);
      queue_item(CMD_SAMPLE, 8'hFE, 1'b0);
      wait_results();

      // No channel enabled: a sample while running is ignored and start
      // does not run the block. The reserved register index changes nothing.
      write_reg(REG_CHANNEL_ENABLE, 9'h000);
      write_reg(REG_RESERVED, 9'h1FF);
      csr_bus.valid <= 1'b0;
      queue_item(CMD_SAMPLE, 8'hC3, 1'b0);
      queue_item(CMD_START, 8'h3C, 1'b0);
      wait_results();

      // Top channel alone with the largest frame count: ring saturates at
      // the buffer depth.
      write_reg(REG_CHANNEL_ENABLE, 9'h080);
      write_reg(REG_FRAME_COUNT, 9'h1FF);
      csr_bus.valid <= 1'b0;
      queue_item(CMD_START, 8'h00, 1'b0);
      queue_item(CMD_SAMPLE, 8'hFF, 1'b0);
      cur_mask       = 8'h80;
      directed_items = items_queued;

      while (items_queued < directed_items + RANDOM_ITEMS) begin
         wait_results();
         phase_count++;
         sender_steady = ($urandom_range(0, 3) == 0);
         pick          = $urandom_range(0, 4);
         paused_pct    = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 50 :
                         (pick == 3) ? 90 : 100;

         if (phase_count == 4) begin
            // Long paused run on one channel drives the request count into
            // saturation, then a few unpaused scans send again.
            cur_mask = MASK_W'(1 << $urandom_range(0, 7));
            write_reg(REG_CHANNEL_ENABLE, {1'b1, cur_mask});
            write_reg(REG_SCAN_MODE, 9'h001);
            csr_bus.valid <= 1'b0;
            queue_item(CMD_START, DATA_W'($urandom), 1'b0);
            queue_samples(270, 100);
            queue_samples(6, 0);
         end else if (phase_count == 8) begin
            // Whole buffer in frame mode: 32 scans of eight fill and wrap it.
            cur_mask = 8'hFF;
            write_reg(REG_CHANNEL_ENABLE, {1'b0, cur_mask});
            write_reg(REG_SCAN_MODE, 9'h000);
            write_reg(REG_FRAME_COUNT, 9'h100);
            csr_bus.valid <= 1'b0;
            queue_item(CMD_START, DATA_W'($urandom), 1'b0);
            queue_samples(264, 0);
         end else begin
            // Random register changes; the block may still be running, so a
            // shortened ring or a moved scan position are exercised too.
            if (phase_count == 1 || $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) cur_mask = '0;
               else if (pick == 1) cur_mask = 8'hFF;
               else if (pick < 4) cur_mask = MASK_W'(1 << $urandom_range(0, 7));
               else cur_mask = MASK_W'($urandom);
               write_reg(REG_CHANNEL_ENABLE, {1'($urandom_range(0, 1)), cur_mask});
            end
            if (phase_count == 1 || $urandom_range(0, 1) == 1) begin
               write_reg(REG_SCAN_MODE, FRAME_W'($urandom));
            end
            if (phase_count == 1 || $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) frames = '0;
               else if (pick == 1) frames = 9'd256;
               else if (pick == 2) frames = 9'h1FF;
               else if (pick == 3) frames = FRAME_W'($urandom);
               else frames = FRAME_W'($urandom_range(1, 4));
               write_reg(REG_FRAME_COUNT, frames);
            end
            if ($urandom_range(0, 19) == 0) write_reg(REG_RESERVED, FRAME_W'($urandom));
            csr_bus.valid <= 1'b0;

            n_on = $countones(cur_mask);
            for (int seq = 0; seq < $urandom_range(1, 4); seq++) begin
               if ($urandom_range(0, 99) < 85) begin
                  // Well-formed: usually a start, whole scans, sometimes a
                  // partial scan on the end and a stop.
                  if ($urandom_range(0, 4) != 0)
                     queue_item(CMD_START, DATA_W'($urandom), 1'($urandom));
                  queue_samples(((n_on == 0) ? 2 : n_on) * $urandom_range(1, 6) +
                                (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0),
                                paused_pct);
                  if ($urandom_range(0, 2) == 0)
                     queue_item(CMD_STOP, DATA_W'($urandom), 1'($urandom));
               end else begin
                  repeat ($urandom_range(1, 8))
                     queue_item(CMD_W'($urandom), DATA_W'($urandom), 1'($urandom));
               end
               // Now and then the sender holds back until the block has
               // answered everything.
               if (seq == 0 && phase_count % 4 == 0) wait_results();
            end
         end
      end

      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d commands in %0d random phases with %0d register writes.",
               items_queued, phase_count, reg_writes);
      $display("Checked %0d results: %0d stored samples, %0d frame sends, peak pending %0d.",
               results_seen, samples_stored, sends_seen, peak_pending);
      if (predicted_results.size() != 0) begin
         failures++;
         $display("%0t: results never arrived, expected %0d more, actual 0", $realtime,
                  predicted_results.size());
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
